FILE: rtl/pft_pkg.sv
package pft_pkg;

    localparam int FRAME_W     = 32;
    localparam int RX_W        = 28;
    localparam int BITS_W      = 5;
    localparam int FRAME_BITS  = 22;
    localparam int REPEAT_BITS = 28;
    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 24;

    localparam logic [3:0] START_CODE = 4'b1110;
    localparam logic [1:0] SFX_UNIT   = 2'b01;
    localparam logic [1:0] SFX_FUNC   = 2'b10;

    typedef enum logic [1:0] {
        CMD_CROSSING  = 2'd0,
        CMD_SEND_UNIT = 2'd1,
        CMD_SEND_FUNC = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        RX_NONE    = 2'd0,
        RX_ADDRESS = 2'd1,
        RX_COMMAND = 2'd2
    } rx_event_t;

    localparam logic [7:0] CODE_TABLE [16] = '{
        8'h69, 8'hA9, 8'h59, 8'h99, 8'h56, 8'h96, 8'h66, 8'hA6,
        8'h6A, 8'hAA, 8'h5A, 8'h9A, 8'h55, 8'h95, 8'h65, 8'hA5
    };

    typedef struct packed {
        logic burst;
        logic busy;
        logic active;
    } tx_stat_t;

    typedef struct packed {
        rx_event_t   event_code;
        logic [3:0]  house;
        logic        house_valid;
        logic [3:0]  unit;
        logic        unit_valid;
        logic [7:0]  func;
    } rx_stat_t;

    typedef struct packed {
        logic       valid;
        logic [4:0] idx;
    } decode_t;

    // idx[4] unused; lowest matching entry wins
    function automatic decode_t decode_pattern(input logic [7:0] pat);
        decode_t res;
        res = '0;
        for (int i = 15; i >= 0; i--) begin
            if (CODE_TABLE[i] == pat) begin
                res.valid = 1'b1;
                res.idx   = 5'(i);
            end
        end
        return res;
    endfunction

endpackage

FILE: rtl/pft_tx.sv
module pft_tx (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic [1:0]          cmd,
    input  logic [3:0]          house,
    input  logic [3:0]          unit,
    input  logic [7:0]          function_code,
    input  logic                wait_three,
    output pft_pkg::tx_stat_t   stat
);

    logic [pft_pkg::FRAME_W-1:0] shift_reg, shift_next;
    logic [pft_pkg::BITS_W-1:0]  bits_reg, bits_next;
    logic                        active_reg, active_next;
    logic                        second_reg, second_next;
    logic                        wait_reg, wait_next;
    logic [pft_pkg::FRAME_W-1:0] rot1, rot11;
    logic [pft_pkg::BITS_W-1:0]  bits_dec;
    logic [7:0]                  key;
    logic [1:0]                  suffix;
    logic                        burst;

    assign rot1     = {shift_reg[pft_pkg::FRAME_W-2:0], shift_reg[pft_pkg::FRAME_W-1]};
    assign rot11    = {rot1[pft_pkg::FRAME_W-11:0], rot1[pft_pkg::FRAME_W-1 -: 10]};
    assign bits_dec = bits_reg - pft_pkg::BITS_W'(1);

    always_comb begin
        shift_next  = shift_reg;
        bits_next   = bits_reg;
        active_next = active_reg;
        second_next = second_reg;
        wait_next   = wait_reg;
        burst       = 1'b0;
        key         = pft_pkg::CODE_TABLE[unit];
        suffix      = pft_pkg::SFX_UNIT;
        if (cmd == pft_pkg::CMD_SEND_FUNC) begin
            key    = function_code;
            suffix = pft_pkg::SFX_FUNC;
        end
        if (en) begin
            unique case (cmd) inside
                pft_pkg::CMD_SEND_UNIT, pft_pkg::CMD_SEND_FUNC: begin
                    shift_next  = {pft_pkg::START_CODE, pft_pkg::CODE_TABLE[house], key,
                                   suffix, 10'b0};
                    bits_next   = pft_pkg::BITS_W'(pft_pkg::FRAME_BITS);
                    second_next = 1'b0;
                    wait_next   = wait_three;
                    active_next = 1'b1;
                end
                pft_pkg::CMD_CROSSING: begin
                    if (active_reg) begin
                        burst      = shift_reg[pft_pkg::FRAME_W-1];
                        shift_next = rot1;
                        bits_next  = bits_dec;
                        if (bits_dec == '0) begin
                            if (second_reg) begin
                                active_next = 1'b0;
                            end else begin
                                second_next = 1'b1;
                                shift_next  = rot11;
                                bits_next   = wait_reg ?
                                              pft_pkg::BITS_W'(pft_pkg::REPEAT_BITS) :
                                              pft_pkg::BITS_W'(pft_pkg::FRAME_BITS);
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg  <= '0;
            bits_reg   <= '0;
            active_reg <= 1'b0;
            second_reg <= 1'b0;
            wait_reg   <= 1'b0;
        end else begin
            shift_reg  <= shift_next;
            bits_reg   <= bits_next;
            active_reg <= active_next;
            second_reg <= second_next;
            wait_reg   <= wait_next;
        end
    end

    assign stat.burst  = burst;
    assign stat.busy   = active_next;
    assign stat.active = active_reg;

endmodule

FILE: rtl/pft_rx.sv
module pft_rx (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                carrier_sample,
    input  logic                carrier_active_low,
    output pft_pkg::rx_stat_t   stat
);

    logic [pft_pkg::RX_W-1:0] shift_reg, shift_next;
    logic [7:0]               hn_reg, hn_next, hp_reg, hp_next;
    logic [7:0]               kn_reg, kn_next, kp_reg, kp_next;
    logic [pft_pkg::RX_W-1:0] shifted;
    pft_pkg::decode_t         hdec, udec;
    logic                     start, match;

    assign shifted = {shift_reg[pft_pkg::RX_W-2:0], carrier_sample ^ carrier_active_low};
    assign start   = shifted[27:24] == pft_pkg::START_CODE;
    assign match   = (shifted[23:16] == hn_reg) && (shifted[15:8] == kn_reg);
    assign hdec    = pft_pkg::decode_pattern(hn_reg);
    assign udec    = pft_pkg::decode_pattern(kn_reg);

    always_comb begin
        shift_next = shift_reg;
        hn_next    = hn_reg;
        hp_next    = hp_reg;
        kn_next    = kn_reg;
        kp_next    = kp_reg;
        stat       = '0;
        if (en) begin
            shift_next = shifted;
            if (start) begin
                hp_next = hn_reg;
                kp_next = kn_reg;
                hn_next = shifted[23:16];
                kn_next = shifted[15:8];
                if (match) begin
                    case (shifted[7:6])
                        pft_pkg::SFX_UNIT: begin
                            stat.event_code  = pft_pkg::RX_ADDRESS;
                            stat.house       = hdec.idx[3:0];
                            stat.house_valid = hdec.valid;
                            stat.unit        = udec.idx[3:0];
                            stat.unit_valid  = udec.valid;
                        end
                        pft_pkg::SFX_FUNC: begin
                            stat.event_code  = pft_pkg::RX_COMMAND;
                            stat.house       = hdec.idx[3:0];
                            stat.house_valid = hdec.valid;
                            stat.func        = kn_reg;
                        end
                        default: ;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg <= '0;
            hn_reg    <= '0;
            hp_reg    <= '0;
            kn_reg    <= '0;
            kp_reg    <= '0;
        end else begin
            shift_reg <= shift_next;
            hn_reg    <= hn_next;
            hp_reg    <= hp_next;
            kn_reg    <= kn_next;
            kp_reg    <= kp_next;
        end
    end

endmodule

FILE: rtl/powerline_frame_transceiver.sv
// A zero-crossing transfer gives its result on m_tvalid in the cycle after acceptance.
// One input transfer per cycle while s_tready is high; send requests and unused codes give no result.
// The result register is a single stage; s_tready drops only while it is full and m_tready is low.
// Reset (aresetn low, synchronous) clears the transmitter, receiver history,
// the carrier polarity register and the result valid flag.
module powerline_frame_transceiver (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic                             cfg_data,   // carrier_active_low
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // carrier_sample, house[3:0], unit[3:0], function_code[7:0], wait_three, zero fill
    input  logic [pft_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic [1:0]                       s_tuser,    // cmd
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // tx_burst, tx_busy, rx_house[3:0], rx_house_valid, rx_unit[3:0],
    // rx_unit_valid, rx_function[7:0], zero fill
    output logic [pft_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic [1:0]                       m_tuser     // rx_event
);

    logic                            polarity_reg;
    logic                            valid_reg, valid_next;
    logic [pft_pkg::OUT_DATA_W-1:0]  data_reg, data_next;
    logic [1:0]                      user_reg, user_next;
    logic                            accept, crossing;
    pft_pkg::tx_stat_t               tx_stat;
    pft_pkg::rx_stat_t               rx_stat;

    assign cfg_ready = 1'b1;
    assign s_tready  = !valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign crossing  = accept && (s_tuser == pft_pkg::CMD_CROSSING);

    pft_tx u_tx (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (accept),
        .cmd           (s_tuser),
        .house         (s_tdata[4:1]),
        .unit          (s_tdata[8:5]),
        .function_code (s_tdata[16:9]),
        .wait_three    (s_tdata[17]),
        .stat          (tx_stat)
    );

    pft_rx u_rx (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .en                 (crossing),
        .carrier_sample     (s_tdata[0]),
        .carrier_active_low (polarity_reg),
        .stat               (rx_stat)
    );

    always_comb begin
        valid_next = valid_reg && !m_tready;
        data_next  = data_reg;
        user_next  = user_reg;
        if (crossing) begin
            valid_next = 1'b1;
            data_next  = {4'b0, rx_stat.func, rx_stat.unit_valid, rx_stat.unit,
                          rx_stat.house_valid, rx_stat.house, tx_stat.busy, tx_stat.burst};
            user_next  = rx_stat.event_code;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            polarity_reg <= 1'b0;
            valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                polarity_reg <= cfg_data;
            end
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        user_reg <= user_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;

    a_send_starts_tx: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (s_tuser == pft_pkg::CMD_SEND_UNIT || s_tuser == pft_pkg::CMD_SEND_FUNC)
        |=> tx_stat.active)
        else $error("send request did not start the transmitter");

    a_crossing_result: assert property (@(posedge aclk) disable iff (!aresetn)
        crossing |=> m_tvalid)
        else $error("zero crossing gave no result");

    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid && !crossing |=> !m_tvalid)
        else $error("result appeared without a zero crossing");

    a_func_only_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != pft_pkg::RX_COMMAND) |-> m_tdata[19:12] == 8'h00)
        else $error("function byte set without a command event");

    a_idle_no_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        crossing && !tx_stat.active |-> !tx_stat.burst && !tx_stat.busy)
        else $error("idle transmitter emitted a burst");

endmodule
